// ===== rtl/edt_pkg.sv =====
// Shared types, constants and the arctangent table for the equirect texel mapper.
// No dependencies; imported by every module of the block.
`default_nettype none
package edt_pkg;
  localparam int CW = 34;  // CORDIC datapath width
  localparam int SW = 31;  // square-root cell width

  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic [31:0]          ang;
  } cordic_t;

  typedef struct packed {
    logic [SW-1:0] v;
    logic [SW-1:0] res;
  } sqrt_t;

  // atan(2^-i) in binary turns, 2^32 per turn
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] t;
    unique case (i)
      0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
      3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
      6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
      9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
      15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
      18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
      21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
      default: t = 32'h0;
    endcase
    return t;
  endfunction

  // Fold the vector into the right half-plane and scale by 2^14.
  function automatic cordic_t cordic_prep(input logic signed [16:0] num,
                                          input logic signed [16:0] den);
    cordic_t c;
    logic signed [CW-1:0] n, d;
    n = CW'(num);
    d = CW'(den);
    if (d < 0) begin
      if (n > 0) begin
        c.ang = 32'h40000000; c.cx = n;  c.cy = -d;
      end else begin
        c.ang = 32'hC0000000; c.cx = -n; c.cy = d;
      end
    end else begin
      c.ang = 32'h0; c.cx = d; c.cy = n;
    end
    c.cx = c.cx <<< 14;
    c.cy = c.cy <<< 14;
    return c;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/equirect_direction_to_texel.sv =====
// Top level of the equirect texel mapper: stream ports, config registers, pipeline.
// Depends on edt_pkg, edt_sqrt_cell and edt_cordic_cell.
//
// Maps a Q1.15 direction to a texel of an equirectangular map. Fully pipelined:
// one direction per clock unless the output stalls, passing through the
// 16-cell square-root chain and the two parallel CORDIC chains.
// The whole pipeline stalls only while the output register holds an untaken result.
// Width and height registers are read live; write them only while the block is idle.
`default_nettype none
module equirect_direction_to_texel #(
  parameter int MAX_WIDTH     = 8192,
  parameter int MAX_HEIGHT    = 4096,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [13:0] cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // dir_x, dir_y, dir_z
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata   // texel_row, texel_column, texel_index, zero pad
);
  import edt_pkg::*;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;
  localparam int   WCAP = (MAX_WIDTH  < 16383) ? MAX_WIDTH  : 16383;
  localparam int   HCAP = (MAX_HEIGHT < 8191)  ? MAX_HEIGHT : 8191;
  localparam int   SQN  = 16;
  localparam int   LAT  = 1 + SQN + 1 + CORDIC_STAGES + 2;

  logic [13:0] img_w, w_eff;
  logic [12:0] img_h, h_eff;
  logic        adv;
  logic [LAT-1:0] vpipe;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_w <= 14'd2048;
      img_h <= 13'd1024;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  img_w <= cfg_wdata;
        CFG_HEIGHT: img_h <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    w_eff <= (img_w == '0) ? 14'd1 : ((img_w > WCAP[13:0]) ? WCAP[13:0] : img_w);
    h_eff <= (img_h == '0) ? 13'd1 : ((img_h > HCAP[12:0]) ? HCAP[12:0] : img_h);
  end

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) vpipe <= '0;
    else if (adv) vpipe <= {vpipe[LAT-2:0], s_axis_tvalid};
  end

  // input stage: y squared
  logic signed [15:0] xs [0:SQN];
  logic signed [15:0] ys [0:SQN];
  logic signed [15:0] zs [0:SQN];
  logic [30:0]        ysq;
  sqrt_t              sq [0:SQN];

  always_ff @(posedge clk) begin
    if (adv) begin
      xs[0] <= s_axis_tdata[15:0];
      ys[0] <= s_axis_tdata[31:16];
      zs[0] <= s_axis_tdata[47:32];
      ysq   <= 31'($signed(s_axis_tdata[31:16]) * $signed(s_axis_tdata[31:16]));
    end
  end

  assign sq[0].v   = 31'h40000000 - ysq;
  assign sq[0].res = '0;

  for (genvar k = 0; k < SQN; k++) begin : g_sqrt
    edt_sqrt_cell #(.STEP(k)) u_cell (
      .clk(clk), .en(adv), .d_in(sq[k]), .d_out(sq[k+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        xs[k+1] <= xs[k];
        ys[k+1] <= ys[k];
        zs[k+1] <= zs[k];
      end
    end
  end

  // fold both vectors and record the exact-axis cases
  cordic_t pc [0:CORDIC_STAGES];
  cordic_t ac [0:CORDIC_STAGES];
  logic [3:0] fl [0:CORDIC_STAGES];  // polar zero, polar neg, az zero, az neg

  always_ff @(posedge clk) begin
    if (adv) begin
      pc[0] <= cordic_prep({1'b0, sq[SQN].res[15:0]}, 17'(ys[SQN]));
      ac[0] <= cordic_prep(17'(zs[SQN]), 17'(xs[SQN]));
      fl[0] <= {sq[SQN].res[15:0] == '0, ys[SQN][15], zs[SQN] == '0, xs[SQN][15]};
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    edt_cordic_cell #(.STAGE(i)) u_pol (
      .clk(clk), .en(adv), .d_in(pc[i]), .d_out(pc[i+1])
    );
    edt_cordic_cell #(.STAGE(i)) u_az (
      .clk(clk), .en(adv), .d_in(ac[i]), .d_out(ac[i+1])
    );
    always_ff @(posedge clk) begin
      if (adv) fl[i+1] <= fl[i];
    end
  end

  // scale angles to texel coordinates
  logic [31:0] pol, u;
  logic [13:0] row_raw, col_raw;
  logic        seam;
  logic [3:0]  ff;

  always_comb begin
    ff  = fl[CORDIC_STAGES];
    pol = ff[3] ? (ff[2] ? 32'h80000000 : 32'h0) : pc[CORDIC_STAGES].ang;
    if (pol[31:30] == 2'b11) pol = 32'h0;
    u   = ff[1] ? (ff[0] ? 32'h80000000 : 32'h0) : ac[CORDIC_STAGES].ang;
    u   = u ^ 32'h80000000;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      row_raw <= 14'(({13'b0, pol} * {32'b0, h_eff}) >> 31);
      col_raw <= 14'(({14'b0, u} * {32'b0, w_eff}) >> 32);
      seam    <= ff[1] && ff[0];
    end
  end

  logic [12:0] row_c;
  logic [13:0] col_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      row_c <= (row_raw > {1'b0, h_eff - 13'd1}) ? h_eff - 13'd1 : row_raw[12:0];
      if (seam || col_raw > w_eff - 14'd1) col_c <= w_eff - 14'd1;
      else col_c <= col_raw;
    end
  end

  logic [26:0] idx;
  assign idx = 27'(row_c * w_eff) + {13'b0, col_c};

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (adv) m_axis_tvalid <= vpipe[LAT-1];
  end

  always_ff @(posedge clk) begin
    if (adv) m_axis_tdata <= {6'b0, idx[24:0], col_c[12:0], row_c[11:0]};
  end

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> {1'b0, m_axis_tdata[11:0]} < h_eff)
    else $error("texel row out of range");
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> {1'b0, m_axis_tdata[24:12]} < w_eff)
    else $error("texel column out of range");
  a_index_match: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[49:25] ==
      25'(m_axis_tdata[11:0] * w_eff + {14'b0, m_axis_tdata[24:12]}))
    else $error("texel index does not match row and column");
endmodule
`default_nettype wire

// ===== rtl/edt_sqrt_cell.sv =====
// One result bit of the pipelined integer square root.
// Depends on edt_pkg.
`default_nettype none
module edt_sqrt_cell #(
  parameter int STEP = 0
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire edt_pkg::sqrt_t d_in,
  output edt_pkg::sqrt_t      d_out
);
  import edt_pkg::*;

  localparam logic [SW:0] BIT = (SW+1)'(1) << (30 - 2*STEP);

  logic [SW:0] trial;
  sqrt_t       nxt;

  always_comb begin
    trial = {1'b0, d_in.res} + BIT;
    if ({1'b0, d_in.v} >= trial) begin
      nxt.v   = d_in.v - trial[SW-1:0];
      nxt.res = (d_in.res >> 1) + BIT[SW-1:0];
    end else begin
      nxt.v   = d_in.v;
      nxt.res = d_in.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_out <= nxt;
  end
endmodule
`default_nettype wire

// ===== rtl/edt_cordic_cell.sv =====
// One vectoring micro-rotation of the CORDIC arctangent chain.
// Depends on edt_pkg.
`default_nettype none
module edt_cordic_cell #(
  parameter int STAGE = 0
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire edt_pkg::cordic_t d_in,
  output edt_pkg::cordic_t      d_out
);
  import edt_pkg::*;

  localparam logic [31:0] ATAN = atan_turn(STAGE);

  logic signed [CW-1:0] dx, dy;
  logic                 pos;
  cordic_t              nxt;

  always_comb begin
    dx  = d_in.cy >>> STAGE;
    dy  = d_in.cx >>> STAGE;
    pos = !d_in.cy[CW-1] && (|d_in.cy);
    if (pos) begin
      nxt.cx  = d_in.cx + dx;
      nxt.cy  = d_in.cy - dy;
      nxt.ang = d_in.ang + ATAN;
    end else begin
      nxt.cx  = d_in.cx - dx;
      nxt.cy  = d_in.cy + dy;
      nxt.ang = d_in.ang - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_out <= nxt;
  end
endmodule
`default_nettype wire
